/* rtl/core/gce_pkg.sv */
// Package with the types, sizes and codes shared by the Gini coefficient engine.
`default_nettype none

package gce_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_W    = 32;
    localparam int FRAC_SHIFT  = 28;
    localparam int COEF_W      = CNT_W + 2;
    localparam int PROD_W      = COEF_W + SAMPLE_W;
    localparam int ACC_W       = 64;
    localparam int NUM_W       = ACC_W + FRAC_SHIFT;
    localparam int D_W         = 2 * CNT_W;
    localparam int DEN_W       = D_W + SAMPLE_W;
    localparam int DIV_CNT_W   = $clog2(NUM_W);

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_DIV = 2'd1;
    localparam logic [1:0] STAT_SAT      = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic signed [31:0] mean_value;
        logic               last_sample;
    } gini_in_t;

    typedef struct packed {
        logic signed [31:0] gini_value;
        logic [10:0]        sample_count;
        logic [1:0]         status_code;
    } gini_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_RD_J,
        ST_LD_J,
        ST_INNER,
        ST_MUL,
        ST_ACC,
        ST_DEN1,
        ST_DEN2,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_j;
        logic ld_j;
        logic inner;
        logic mul;
        logic acc;
        logic den1;
        logic den2;
        logic div_init;
        logic div_step;
        logic out_load;
        logic start;
    } cmd_t;

    typedef struct packed {
        logic last_taken;
        logic ovf;
        logic k_done;
        logic j_done;
        logic zero_div;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/core/gce_ctrl.sv */
// Controller state machine that sequences loading, ranking, division and output.
`default_nettype none

module gce_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  gce_pkg::stat_t  stat,
    output gce_pkg::cmd_t   cmd
);

    gce_pkg::state_t state_reg;
    gce_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gce_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            gce_pkg::ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (stat.last_taken)
                begin
                    state_next = gce_pkg::ST_START;
                end
            end
            gce_pkg::ST_START:
            begin
                cmd.start = 1'b1;
                if (stat.ovf)
                begin
                    state_next = gce_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = gce_pkg::ST_RD_J;
                end
            end
            gce_pkg::ST_RD_J:
            begin
                cmd.rd_j   = 1'b1;
                state_next = gce_pkg::ST_LD_J;
            end
            gce_pkg::ST_LD_J:
            begin
                cmd.ld_j   = 1'b1;
                state_next = gce_pkg::ST_INNER;
            end
            gce_pkg::ST_INNER:
            begin
                cmd.inner = 1'b1;
                if (stat.k_done)
                begin
                    state_next = gce_pkg::ST_MUL;
                end
            end
            gce_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = gce_pkg::ST_ACC;
            end
            gce_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (stat.j_done)
                begin
                    state_next = gce_pkg::ST_DEN1;
                end
                else
                begin
                    state_next = gce_pkg::ST_RD_J;
                end
            end
            gce_pkg::ST_DEN1:
            begin
                cmd.den1   = 1'b1;
                state_next = gce_pkg::ST_DEN2;
            end
            gce_pkg::ST_DEN2:
            begin
                cmd.den2 = 1'b1;
                if (stat.zero_div)
                begin
                    state_next = gce_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = gce_pkg::ST_DIV_INIT;
                end
            end
            gce_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = gce_pkg::ST_DIV;
            end
            gce_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = gce_pkg::ST_FINISH;
                end
            end
            gce_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = gce_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = gce_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/gce_datapath.sv */
// Datapath with the sample memory, rank counter, accumulator, divider and output register.
`default_nettype none

module gce_datapath (
    input  wire                clk,
    input  wire                rst_n,
    input  gce_pkg::cmd_t      cmd,
    output gce_pkg::stat_t     stat,
    input  wire                in_valid,
    output logic               in_stall,
    input  gce_pkg::gini_in_t  in_data,
    output logic               out_valid,
    input  wire                out_stall,
    output gce_pkg::gini_out_t out_data,
    input  wire                cfg_wr_en,
    input  wire                cfg_wr_data
);

    localparam int AW = gce_pkg::ADDR_W;
    localparam int CW = gce_pkg::CNT_W;

    logic signed [gce_pkg::SAMPLE_W-1:0] mem [gce_pkg::MAX_SAMPLES];
    logic signed [gce_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]                       rd_addr;

    logic                                mode_reg;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic                                ovf_reg;
    logic                                ovf_next;
    logic signed [31:0]                  mean_reg;
    logic [CW-1:0]                       j_reg;
    logic [CW-1:0]                       kd_reg;
    logic [CW-1:0]                       rank_reg;
    logic signed [gce_pkg::SAMPLE_W-1:0] xj_reg;
    logic signed [gce_pkg::PROD_W-1:0]   prod_reg;
    logic signed [gce_pkg::ACC_W-1:0]    acc_reg;
    logic [gce_pkg::D_W-1:0]             d_reg;
    logic [31:0]                         mag_mean_reg;
    logic                                neg_reg;
    logic                                zero_reg;
    logic [gce_pkg::DEN_W-1:0]           den_reg;
    logic [gce_pkg::NUM_W-1:0]           num_reg;
    logic [gce_pkg::NUM_W-1:0]           q_reg;
    logic [gce_pkg::DEN_W-1:0]           rem_reg;
    logic [gce_pkg::DIV_CNT_W-1:0]       div_cnt_reg;
    logic                                out_valid_reg;
    gce_pkg::gini_out_t                  out_reg;

    logic                                accept;
    logic                                less;
    logic signed [gce_pkg::COEF_W-1:0]   coef;
    logic [gce_pkg::ACC_W-1:0]           mag_acc;
    logic [gce_pkg::DEN_W:0]             rem_sh;
    logic                                sat;
    logic [31:0]                         limit;
    gce_pkg::gini_out_t                  res;

    assign accept   = cmd.load && in_valid;
    assign in_stall = !cmd.load;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (count_reg < CW'(gce_pkg::MAX_SAMPLES))
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_comb
    begin
        rd_addr = '0;
        if (cmd.rd_j)
        begin
            rd_addr = j_reg[AW-1:0];
        end
        else if (cmd.inner)
        begin
            rd_addr = AW'(kd_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && count_reg < CW'(gce_pkg::MAX_SAMPLES))
        begin
            mem[count_reg[AW-1:0]] <= in_data.sample_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign less = (rd_data_reg < xj_reg) || ((rd_data_reg == xj_reg) && (kd_reg < j_reg));
    assign coef = $signed({1'b0, rank_reg, 1'b0}) - $signed({2'b00, count_reg})
                + $signed(gce_pkg::COEF_W'(1));
    assign mag_acc = acc_reg[gce_pkg::ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign rem_sh  = {rem_reg, num_reg[gce_pkg::NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.last_sample)
        begin
            mean_reg <= in_data.mean_value;
        end
        if (cmd.start)
        begin
            j_reg   <= '0;
            acc_reg <= '0;
        end
        if (cmd.ld_j)
        begin
            xj_reg   <= rd_data_reg;
            rank_reg <= '0;
            kd_reg   <= '0;
        end
        if (cmd.inner)
        begin
            rank_reg <= rank_reg + CW'(less);
            kd_reg   <= kd_reg + 1'b1;
        end
        if (cmd.mul)
        begin
            prod_reg <= gce_pkg::PROD_W'(coef) * gce_pkg::PROD_W'(xj_reg);
        end
        if (cmd.acc)
        begin
            acc_reg <= acc_reg + gce_pkg::ACC_W'(prod_reg);
            j_reg   <= j_reg + 1'b1;
        end
        if (cmd.den1)
        begin
            if (mode_reg)
            begin
                d_reg <= gce_pkg::D_W'(count_reg) * gce_pkg::D_W'(count_reg - 1'b1);
            end
            else
            begin
                d_reg <= gce_pkg::D_W'(count_reg) * gce_pkg::D_W'(count_reg);
            end
            mag_mean_reg <= mean_reg[31] ? (~mean_reg + 1'b1) : mean_reg;
            neg_reg      <= acc_reg[gce_pkg::ACC_W-1] ^ mean_reg[31];
        end
        if (cmd.den2)
        begin
            den_reg  <= gce_pkg::DEN_W'(d_reg) * gce_pkg::DEN_W'(mag_mean_reg);
            zero_reg <= (d_reg == '0) || (mean_reg == '0);
        end
        if (cmd.div_init)
        begin
            num_reg     <= {mag_acc, {gce_pkg::FRAC_SHIFT{1'b0}}};
            q_reg       <= '0;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg     <= {num_reg[gce_pkg::NUM_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= gce_pkg::DEN_W'(rem_sh - {1'b0, den_reg});
                q_reg   <= {q_reg[gce_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[gce_pkg::DEN_W-1:0];
                q_reg   <= {q_reg[gce_pkg::NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= res;
        end
    end

    assign limit = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign sat   = (q_reg[gce_pkg::NUM_W-1:32] != '0) || (q_reg[31:0] > limit);

    always_comb
    begin
        res.sample_count = count_reg;
        res.gini_value   = '0;
        res.status_code  = gce_pkg::STAT_OK;
        if (ovf_reg)
        begin
            res.status_code = gce_pkg::STAT_OVERFLOW;
        end
        else if (zero_reg)
        begin
            res.status_code = gce_pkg::STAT_ZERO_DIV;
        end
        else if (sat)
        begin
            res.status_code = gce_pkg::STAT_SAT;
            res.gini_value  = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            res.gini_value = neg_reg ? -$signed(q_reg[31:0]) : $signed(q_reg[31:0]);
        end
    end

    assign stat.last_taken = accept && in_data.last_sample;
    assign stat.ovf        = ovf_reg;
    assign stat.k_done     = (kd_reg == count_reg - 1'b1);
    assign stat.j_done     = (j_reg == count_reg - 1'b1);
    assign stat.zero_div   = (d_reg == '0) || (mean_reg == '0);
    assign stat.div_done   = (div_cnt_reg == gce_pkg::DIV_CNT_W'(gce_pkg::NUM_W - 1));
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(gce_pkg::MAX_SAMPLES))
        else $error("Sample count exceeds capacity.");
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("Result loaded over a pending transaction.");
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (count_reg == '0) && !ovf_reg)
        else $error("Data set not cleared after a result.");
    a_stall_outside_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.inner || cmd.div_step) |-> in_stall)
        else $error("Input open while a computation runs.");
`endif

endmodule

`default_nettype wire

/* rtl/core/gini_coefficient_engine.sv */
// Top level of the Gini coefficient engine: controller and datapath.
//
// Input transactions carry one signed Q16.16 sample each; the transaction with
// last_sample set also carries the mean and starts the computation. Samples are
// taken at one per cycle while the block is loading, up to 1024 of them; any
// further samples are dropped and the result reports too many samples.
// After the last sample the input is stalled while the engine ranks each stored
// sample by a sweep over the sample memory, one read per cycle, then forms the
// divisor in ST_DEN1 and ST_DEN2, loads the divider in ST_DIV_INIT and divides
// in ST_DIV, one quotient bit per cycle. When too many samples arrived the
// engine goes straight to the result, and on a zero divisor it skips the
// division. The next data set is taken only after the result of the last one
// is loaded into the output register.
// The single result transaction appears in an output register. If the receiver
// stalls, the result holds and the engine waits before loading a new one;
// the input stays stalled meanwhile.
// Reset clears the sample count, overflow flag, mode register and output valid;
// the sample memory needs no clearing. The mode register is written through
// cfg_wr_en and cfg_wr_data, by the user only while idle; it is not enforced.
`default_nettype none

module gini_coefficient_engine (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  gce_pkg::gini_in_t  in_data,
    output logic               out_valid,
    input  wire                out_stall,
    output gce_pkg::gini_out_t out_data,
    input  wire                cfg_wr_en,
    input  wire                cfg_wr_data
);

    gce_pkg::cmd_t  cmd;
    gce_pkg::stat_t stat;

    gce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    gce_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule

`default_nettype wire
